>>> rtl/hrlc_pkg.sv
package hrlc_pkg;

    localparam int unsigned POS_W       = 14;
    localparam int unsigned CFG_W       = 14;
    localparam int unsigned VER_W       = 3;

    localparam logic [POS_W-1:0] POS_LAST    = {POS_W{1'b1}};
    localparam logic [CFG_W-1:0] MAX_LINE    = CFG_W'(8192);
    localparam logic [CFG_W-1:0] MAX_LEN_RST = CFG_W'(8192);
    localparam logic [VER_W-1:0] VERSION_LEN = VER_W'(7);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    // expected text "HTTP/1."
    function automatic logic [7:0] version_char(input logic [VER_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h48;  // H
            3'd1:    ch = 8'h54;  // T
            3'd2:    ch = 8'h54;  // T
            3'd3:    ch = 8'h50;  // P
            3'd4:    ch = 8'h2F;  // /
            3'd5:    ch = 8'h31;  // 1
            3'd6:    ch = 8'h2E;  // .
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/hrlc_in_if.sv
interface hrlc_in_if;
    logic       valid;
    logic       ready;
    logic       start_new;
    logic [7:0] byte_value;

    modport source (output valid, output start_new, output byte_value, input ready);
    modport sink   (input valid, input start_new, input byte_value, output ready);
endinterface

>>> rtl/hrlc_out_if.sv
interface hrlc_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    line_status;
    logic [hrlc_pkg::POS_W-1:0]    method_start;
    logic [hrlc_pkg::POS_W-1:0]    method_end;
    logic [hrlc_pkg::POS_W-1:0]    url_end;
    logic [hrlc_pkg::POS_W-1:0]    bytes_consumed;

    modport source (output valid, output line_status, output method_start,
                    output method_end, output url_end, output bytes_consumed,
                    input ready);
    modport sink   (input valid, input line_status, input method_start,
                    input method_end, input url_end, input bytes_consumed,
                    output ready);
endinterface

>>> rtl/http_request_line_checker_top.sv
// Channel    | Dir | Beat payload
// -----------+-----+-----------------------------------------------------------
// req        | in  | start_new, byte_value
// rsp        | out | line_status, method_start, method_end, url_end, bytes_consumed
// cfg_wr_*   | in  | max_line_length (14 bit), write only, no handshake
//
// One beat per cycle while rsp is not stalled; each req beat gives one rsp beat.
// Pace is set by the state update between the input stage and the
// state/result registers, which double as the rsp payload.
// Reset: state cleared (status pending, skipping leading CR/LF), limit = 8192.
// A stalled rsp holds the state; the input stage keeps one beat while it waits.
module http_request_line_checker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    hrlc_in_if.sink                       req,
    hrlc_out_if.source                    rsp,
    input  logic                          cfg_wr_en,
    input  logic [hrlc_pkg::CFG_W-1:0]    cfg_wr_data
);

    localparam int unsigned PW = hrlc_pkg::POS_W;
    localparam int unsigned VW = hrlc_pkg::VER_W;

    // limit register
    logic [hrlc_pkg::CFG_W-1:0] max_len_reg;

    // input stage
    logic       stage_vld_reg;
    logic       stage_new_reg;
    logic [7:0] stage_byte_reg;

    // parser state; these also form the result beat
    logic               rsp_vld_reg, rsp_vld_next;
    hrlc_pkg::status_t  status_reg, status_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               skip_reg, skip_next;
    logic [PW-1:0]      begin_reg, begin_next;
    logic [1:0]         spc_reg, spc_next;
    logic [PW-1:0]      mstop_reg, mstop_next;
    logic [PW-1:0]      ustop_reg, ustop_next;
    logic [VW-1:0]      vm_reg, vm_next;
    logic               vbad_reg, vbad_next;
    logic               pcr_reg, pcr_next;

    logic advance;

    assign advance   = stage_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign req.ready = !stage_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= hrlc_pkg::MAX_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            stage_vld_reg <= req.valid;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            stage_new_reg  <= req.start_new;
            stage_byte_reg <= req.byte_value;
        end
    end

    // next-state logic for one byte
    always_comb
    begin
        hrlc_pkg::status_t  st_c;
        logic [PW-1:0]      pos_c;
        logic               skip_c;
        logic [PW-1:0]      begin_c;
        logic [1:0]         spc_c;
        logic [PW-1:0]      mstop_c;
        logic [PW-1:0]      ustop_c;
        logic [VW-1:0]      vm_c;
        logic               vbad_c;
        logic               pcr_c;
        logic [hrlc_pkg::CFG_W-1:0] limit;
        logic [PW:0]        line_len;
        logic               is_cr;
        logic               is_lf;
        logic               is_sp;
        hrlc_pkg::status_t  st;

        // start_new clears before the byte is looked at
        if (stage_new_reg)
        begin
            st_c    = hrlc_pkg::ST_PENDING;
            pos_c   = '0;
            skip_c  = 1'b1;
            begin_c = '0;
            spc_c   = '0;
            mstop_c = '0;
            ustop_c = '0;
            vm_c    = '0;
            vbad_c  = 1'b0;
            pcr_c   = 1'b0;
        end
        else
        begin
            st_c    = status_reg;
            pos_c   = pos_reg;
            skip_c  = skip_reg;
            begin_c = begin_reg;
            spc_c   = spc_reg;
            mstop_c = mstop_reg;
            ustop_c = ustop_reg;
            vm_c    = vm_reg;
            vbad_c  = vbad_reg;
            pcr_c   = pcr_reg;
        end

        limit    = (max_len_reg > hrlc_pkg::MAX_LINE) ? hrlc_pkg::MAX_LINE : max_len_reg;
        line_len = {1'b0, pos_c} - {1'b0, begin_c} + (PW+1)'(1);
        is_cr    = (stage_byte_reg == hrlc_pkg::CHAR_CR);
        is_lf    = (stage_byte_reg == hrlc_pkg::CHAR_LF);
        is_sp    = (stage_byte_reg == hrlc_pkg::CHAR_SPACE);
        st       = hrlc_pkg::ST_PENDING;

        status_next = st_c;
        pos_next    = pos_c;
        skip_next   = skip_c;
        begin_next  = begin_c;
        spc_next    = spc_c;
        mstop_next  = mstop_c;
        ustop_next  = ustop_c;
        vm_next     = vm_c;
        vbad_next   = vbad_c;
        pcr_next    = pcr_c;

        // complete or error: byte ignored, stored result repeated
        if (st_c == hrlc_pkg::ST_PENDING)
        begin
            if (pos_c == hrlc_pkg::POS_LAST)
            begin
                st = hrlc_pkg::ST_ERROR;
            end
            else
            begin
                pos_next = pos_c + PW'(1);
                if (skip_c && (is_cr || is_lf))
                begin
                    begin_next = pos_c + PW'(1);
                end
                else
                begin
                    skip_next = 1'b0;
                    if (line_len > {1'b0, limit})
                    begin
                        st = hrlc_pkg::ST_ERROR;
                    end
                    else if (is_sp)
                    begin
                        unique case (spc_c)
                            2'd0:
                            begin
                                mstop_next = pos_c;
                                spc_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                ustop_next = pos_c;
                                spc_next   = 2'd2;
                            end
                            default:
                            begin
                                st = hrlc_pkg::ST_ERROR;
                            end
                        endcase
                    end
                    else if (is_lf)
                    begin
                        if (!pcr_c || spc_c != 2'd2 || vm_c != hrlc_pkg::VERSION_LEN || vbad_c)
                        begin
                            st = hrlc_pkg::ST_ERROR;
                        end
                        else
                        begin
                            st = hrlc_pkg::ST_DONE;
                        end
                    end
                    else if (spc_c == 2'd2 && vm_c < hrlc_pkg::VERSION_LEN)
                    begin
                        if (stage_byte_reg != hrlc_pkg::version_char(vm_c))
                        begin
                            vbad_next = 1'b1;
                        end
                        vm_next = vm_c + VW'(1);
                    end
                end
            end
            pcr_next    = is_cr;
            status_next = st;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end
        else
        begin
            rsp_vld_next = rsp_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
            status_reg  <= hrlc_pkg::ST_PENDING;
            pos_reg     <= '0;
            skip_reg    <= 1'b1;
            begin_reg   <= '0;
            spc_reg     <= '0;
            mstop_reg   <= '0;
            ustop_reg   <= '0;
            vm_reg      <= '0;
            vbad_reg    <= 1'b0;
            pcr_reg     <= 1'b0;
        end
        else
        begin
            rsp_vld_reg <= rsp_vld_next;
            if (advance)
            begin
                status_reg <= status_next;
                pos_reg    <= pos_next;
                skip_reg   <= skip_next;
                begin_reg  <= begin_next;
                spc_reg    <= spc_next;
                mstop_reg  <= mstop_next;
                ustop_reg  <= ustop_next;
                vm_reg     <= vm_next;
                vbad_reg   <= vbad_next;
                pcr_reg    <= pcr_next;
            end
        end
    end

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.line_status    = status_reg;
    assign rsp.method_start   = begin_reg;
    assign rsp.method_end     = mstop_reg;
    assign rsp.url_end        = ustop_reg;
    assign rsp.bytes_consumed = pos_reg;

    // sticky status holds unless a new request starts
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !stage_new_reg && status_reg != hrlc_pkg::ST_PENDING)
        |=> (status_reg == $past(status_reg)))
        else $error("sticky status changed");

    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == hrlc_pkg::ST_DONE)
        |-> (spc_reg == 2'd2 && vm_reg == hrlc_pkg::VERSION_LEN && !vbad_reg))
        else $error("complete without full request line");

    a_begin_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        begin_reg <= pos_reg)
        else $error("method start beyond position");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_vld_reg && !advance) |=> stage_vld_reg)
        else $error("input stage beat lost");

    a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mstop_reg != '0 && ustop_reg != '0) |-> (ustop_reg > mstop_reg))
        else $error("url end not after method end");

endmodule
